@@ src/mtt_pkg.sv @@
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and character codes for the markup tag tokenizer.
// ----------------------------------------------------------------------------
package mtt_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 3;

    // delimiter bytes
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;  // '"'
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;  // newline
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;  // ' '

    typedef enum logic [KIND_W-1:0] {
        KIND_TEXT  = 3'd0,
        KIND_OPEN  = 3'd1,
        KIND_CLOSE = 3'd2,
        KIND_ANAME = 3'd3,
        KIND_AVAL  = 3'd4
    } t_kind;

    // one result beat
    typedef struct packed {
        logic              has_char;
        t_kind             kind;
        logic [CHAR_W-1:0] out_char;
        logic              token_start;
        logic              end_of_text;
    } t_result;

endpackage

@@ src/mtt_stream_if.sv @@
// ----------------------------------------------------------------------------
// mtt stream interfaces
// Valid/ready channels for input bytes and labeled result beats.
// ----------------------------------------------------------------------------
interface mtt_in_if;
    import mtt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] chr;
    logic              last;

    modport source (output valid, chr, last, input ready);
    modport sink   (input valid, chr, last, output ready);
endinterface

interface mtt_out_if;
    import mtt_pkg::*;

    logic              valid;
    logic              ready;
    logic              has_char;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] out_char;
    logic              token_start;
    logic              end_of_text;

    modport source (output valid, has_char, kind, out_char, token_start, end_of_text,
                    input ready);
    modport sink   (input valid, has_char, kind, out_char, token_start, end_of_text,
                    output ready);
endinterface

@@ src/markup_tag_tokenizer.sv @@
// Each accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle unless o_out stalls (context feedback in mtt_lexer).
// Input and output registers decouple the channels; i_in.ready stays high while
// the output register drains or is free.
// Reset (i_rst_n low, synchronous): stages emptied, lexing context back to text.
// ----------------------------------------------------------------------------
// markup_tag_tokenizer
// Byte-serial markup lexer: labels each content byte with its token kind
// (text, open tag, close tag, attribute name, attribute value) and flags the
// first byte of every token. One result beat per input beat.
// ----------------------------------------------------------------------------
module markup_tag_tokenizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mtt_in_if.sink    i_in,
    mtt_out_if.source o_out
);
    import mtt_pkg::*;

    // input register stage
    logic              r_a_valid;
    logic [CHAR_W-1:0] r_a_chr;
    logic              r_a_last;

    // result register stage
    logic              r_b_valid;
    t_result           r_b_res;

    t_result           lex_res;
    logic              a_advance;   // stage A beat moves into the result register
    logic              in_take;

    // A beat leaves stage A when the result register is empty or being drained.
    assign a_advance = r_a_valid && (!r_b_valid || o_out.ready);
    assign i_in.ready = !r_a_valid || a_advance;
    assign in_take   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_chr  <= i_in.chr;
            r_a_last <= i_in.last;
        end
    end

    // context machine; state only advances when the beat is committed
    mtt_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (a_advance),
        .i_chr   (r_a_chr),
        .i_last  (r_a_last),
        .o_res   (lex_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_advance) begin
            r_b_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_advance) begin
            r_b_res <= lex_res;
        end
    end

    assign o_out.valid       = r_b_valid;
    assign o_out.has_char    = r_b_res.has_char;
    assign o_out.kind        = r_b_res.kind;
    assign o_out.out_char    = r_b_res.out_char;
    assign o_out.token_start = r_b_res.token_start;
    assign o_out.end_of_text = r_b_res.end_of_text;

endmodule

@@ src/mtt_lexer.sv @@
// ----------------------------------------------------------------------------
// mtt_lexer
// Lexing context machine: classifies one byte and advances context on i_step.
// ----------------------------------------------------------------------------
module mtt_lexer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic [mtt_pkg::CHAR_W-1:0] i_chr,
    input  logic                     i_last,
    output mtt_pkg::t_result         o_res
);
    import mtt_pkg::*;

    typedef enum logic [2:0] {
        CX_TEXT   = 3'd0,
        CX_LT     = 3'd1,
        CX_NAME   = 3'd2,
        CX_ANAME  = 3'd3,
        CX_AVAL   = 3'd4,
        CX_QUOTED = 3'd5,
        CX_SKIP   = 3'd6
    } t_ctx;

    t_ctx  r_ctx, n_ctx;
    logic  r_in_token, n_in_token;
    logic  r_close, n_close;
    logic  tok_mid;   // in_token after the context rules, before this byte is counted
    logic  emit;
    t_kind kind;
    logic  is_sp_q;

    assign is_sp_q = (i_chr == CH_SPACE) || (i_chr == CH_QUOTE);

    always_comb begin
        n_ctx   = r_ctx;
        n_close = r_close;
        tok_mid = r_in_token;
        emit    = 1'b0;
        kind    = KIND_TEXT;
        case (r_ctx)
            CX_LT: begin
                tok_mid = 1'b0;
                if (i_chr == CH_SLASH) begin
                    n_close = 1'b1;
                    n_ctx   = CX_NAME;
                end else if (i_chr == CH_GT) begin
                    n_ctx = CX_TEXT;
                end else if (is_sp_q) begin
                    n_close = 1'b0;
                    n_ctx   = CX_ANAME;
                end else begin
                    n_close = 1'b0;
                    n_ctx   = CX_NAME;
                    emit    = 1'b1;
                    kind    = KIND_OPEN;
                end
            end
            CX_NAME: begin
                if (i_chr == CH_GT) begin
                    n_ctx   = CX_TEXT;
                    tok_mid = 1'b0;
                end else if (is_sp_q) begin
                    n_ctx   = r_close ? CX_SKIP : CX_ANAME;
                    tok_mid = 1'b0;
                end else begin
                    emit = 1'b1;
                    kind = r_close ? KIND_CLOSE : KIND_OPEN;
                end
            end
            CX_ANAME: begin
                if (i_chr == CH_GT) begin
                    n_ctx   = CX_TEXT;
                    tok_mid = 1'b0;
                end else if (i_chr == CH_EQ) begin
                    n_ctx   = CX_AVAL;
                    tok_mid = 1'b0;
                end else if (is_sp_q) begin
                    tok_mid = 1'b0;
                end else begin
                    emit = 1'b1;
                    kind = KIND_ANAME;
                end
            end
            CX_AVAL: begin
                if (i_chr == CH_QUOTE) begin
                    // quote before any value byte opens a quoted value
                    n_ctx   = r_in_token ? CX_ANAME : CX_QUOTED;
                    tok_mid = 1'b0;
                end else if (i_chr == CH_SPACE) begin
                    n_ctx   = CX_ANAME;
                    tok_mid = 1'b0;
                end else if (i_chr == CH_GT) begin
                    n_ctx   = CX_TEXT;
                    tok_mid = 1'b0;
                end else begin
                    emit = 1'b1;
                    kind = KIND_AVAL;
                end
            end
            CX_QUOTED: begin
                if (i_chr == CH_QUOTE) begin
                    n_ctx   = CX_ANAME;
                    tok_mid = 1'b0;
                end else if (i_chr == CH_SPACE) begin
                    tok_mid = 1'b0;
                end else begin
                    emit = 1'b1;
                    kind = KIND_AVAL;
                end
            end
            CX_SKIP: begin
                if (i_chr == CH_GT) begin
                    n_ctx = CX_TEXT;
                end
                tok_mid = 1'b0;
            end
            default: begin
                // text, and the unused code
                n_ctx = CX_TEXT;
                if (i_chr == CH_LT) begin
                    n_ctx   = CX_LT;
                    tok_mid = 1'b0;
                end else if (i_chr != CH_NL) begin
                    emit = 1'b1;
                    kind = KIND_TEXT;
                end
            end
        endcase

        n_in_token = emit | tok_mid;
        if (i_last) begin
            n_ctx      = CX_TEXT;
            n_in_token = 1'b0;
            n_close    = 1'b0;
        end

        o_res.has_char    = emit;
        o_res.kind        = emit ? kind : KIND_TEXT;
        o_res.out_char    = emit ? i_chr : '0;
        o_res.token_start = emit & ~tok_mid;
        o_res.end_of_text = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx      <= CX_TEXT;
            r_in_token <= 1'b0;
            r_close    <= 1'b0;
        end else if (i_step) begin
            r_ctx      <= n_ctx;
            r_in_token <= n_in_token;
            r_close    <= n_close;
        end
    end

`ifndef SYNTHESIS
    a_start_has_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.token_start |-> o_res.has_char)
        else $error("token start without content byte");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_ctx == CX_TEXT && !r_in_token && !r_close))
        else $error("context not cleared after last byte");

    a_close_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.has_char && o_res.kind == KIND_CLOSE) |-> (r_close && r_ctx == CX_NAME))
        else $error("close tag byte outside close tag name");

    a_emit_opens_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.has_char && !i_last) |=> r_in_token)
        else $error("token not open after content byte");
`endif

endmodule

@@ bench/mtt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_checker
// Watches both channels of the markup tag tokenizer. It labels every accepted
// input byte with its own copy of the lexing context, queues the labels, and
// compares each accepted result beat with the oldest one.
// ----------------------------------------------------------------------------
module mtt_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mtt_in_if    i_bytes,
    mtt_out_if   i_labels,
    output int   o_fail_count,
    output int   o_pending
);
    import mtt_pkg::*;

    typedef enum logic [2:0] {
        LX_TEXT   = 3'd0,
        LX_LT     = 3'd1,
        LX_NAME   = 3'd2,
        LX_ANAME  = 3'd3,
        LX_AVAL   = 3'd4,
        LX_QUOTED = 3'd5,
        LX_SKIP   = 3'd6
    } t_lex;

    t_lex    lex       = LX_TEXT;
    logic    tok_open  = 1'b0;
    logic    close_tag = 1'b0;
    t_result label_q[$];
    t_result want;
    int      n_fail    = 0;
    int      n_beats   = 0;

    assign o_fail_count = n_fail;
    assign o_pending    = label_q.size();

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_fail++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] exp_val);
        if (got !== exp_val)
            report($sformatf("beat %0d %s got %0h want %0h", n_beats, name, got, exp_val));
    endtask

    // Label one byte and advance the lexing context.
    function automatic t_result label_byte(input logic [CHAR_W-1:0] c, input logic lst);
        t_result r;
        logic    emit;
        t_kind   k;
        emit = 1'b0;
        k    = KIND_TEXT;
        case (lex)
            LX_LT: begin
                if (c == CH_SLASH) begin
                    close_tag = 1'b1;
                    lex       = LX_NAME;
                end else if (c == CH_GT) begin
                    lex = LX_TEXT;
                end else if (c == CH_SPACE || c == CH_QUOTE) begin
                    close_tag = 1'b0;
                    lex       = LX_ANAME;
                end else begin
                    close_tag = 1'b0;
                    lex       = LX_NAME;
                    emit      = 1'b1;
                    k         = KIND_OPEN;
                end
                tok_open = 1'b0;
            end
            LX_NAME: begin
                if (c == CH_GT) begin
                    lex      = LX_TEXT;
                    tok_open = 1'b0;
                end else if (c == CH_SPACE || c == CH_QUOTE) begin
                    lex      = close_tag ? LX_SKIP : LX_ANAME;
                    tok_open = 1'b0;
                end else begin
                    emit = 1'b1;
                    k    = close_tag ? KIND_CLOSE : KIND_OPEN;
                end
            end
            LX_ANAME: begin
                if (c == CH_GT) begin
                    lex      = LX_TEXT;
                    tok_open = 1'b0;
                end else if (c == CH_EQ) begin
                    lex      = LX_AVAL;
                    tok_open = 1'b0;
                end else if (c == CH_SPACE || c == CH_QUOTE) begin
                    tok_open = 1'b0;
                end else begin
                    emit = 1'b1;
                    k    = KIND_ANAME;
                end
            end
            LX_AVAL: begin
                if (c == CH_QUOTE) begin
                    lex      = tok_open ? LX_ANAME : LX_QUOTED;
                    tok_open = 1'b0;
                end else if (c == CH_SPACE) begin
                    lex      = LX_ANAME;
                    tok_open = 1'b0;
                end else if (c == CH_GT) begin
                    lex      = LX_TEXT;
                    tok_open = 1'b0;
                end else begin
                    emit = 1'b1;
                    k    = KIND_AVAL;
                end
            end
            LX_QUOTED: begin
                if (c == CH_QUOTE) begin
                    lex      = LX_ANAME;
                    tok_open = 1'b0;
                end else if (c == CH_SPACE) begin
                    tok_open = 1'b0;
                end else begin
                    emit = 1'b1;
                    k    = KIND_AVAL;
                end
            end
            LX_SKIP: begin
                if (c == CH_GT)
                    lex = LX_TEXT;
                tok_open = 1'b0;
            end
            default: begin
                lex = LX_TEXT;
                if (c == CH_LT) begin
                    lex      = LX_LT;
                    tok_open = 1'b0;
                end else if (c != CH_NL) begin
                    emit = 1'b1;
                    k    = KIND_TEXT;
                end
            end
        endcase

        r.has_char    = emit;
        r.kind        = emit ? k : KIND_TEXT;
        r.out_char    = emit ? c : '0;
        r.token_start = emit && !tok_open;
        r.end_of_text = lst;

        if (emit)
            tok_open = 1'b1;
        // final byte: next one starts a fresh text
        if (lst) begin
            lex       = LX_TEXT;
            tok_open  = 1'b0;
            close_tag = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lex       = LX_TEXT;
            tok_open  = 1'b0;
            close_tag = 1'b0;
            label_q.delete();
        end else begin
            // result side first: a byte taken at this edge only reaches the input
            // register, so it can never match a beat leaving at the same edge
            if (i_labels.valid && i_labels.ready) begin
                if (label_q.size() == 0) begin
                    report($sformatf("beat %0d arrived with nothing expected", n_beats));
                end else begin
                    want = label_q.pop_front();
                    check_field("has_char", 8'(i_labels.has_char), 8'(want.has_char));
                    check_field("kind", 8'(i_labels.kind), 8'(want.kind));
                    check_field("out_char", i_labels.out_char, want.out_char);
                    check_field("token_start", 8'(i_labels.token_start),
                                8'(want.token_start));
                    check_field("end_of_text", 8'(i_labels.end_of_text),
                                8'(want.end_of_text));
                end
                n_beats++;
            end
            if (i_bytes.valid && i_bytes.ready)
                label_q.push_back(label_byte(i_bytes.chr, i_bytes.last));
        end
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the markup tag tokenizer: a short directed document,
// then random markup (tags, attributes, quoted values, text, junk) with random
// idling on both channels and one long output stall. Checking is in mtt_checker.
// ----------------------------------------------------------------------------
module tb;
    import mtt_pkg::*;

    localparam int N_RANDOM    = 1800;     // random bytes after the directed part
    localparam int HOLD_CYCLES = 300;      // one long output stall
    localparam int CYCLE_LIMIT = 1000000;  // watchdog

    logic i_clk;
    logic i_rst_n;
    logic hold_req;     // asks the result side for its long stall
    bit   burst;        // sender offers bytes back to back
    int   doc_left;     // bytes left before the next end-of-text mark
    int   fail_count;
    int   pending;

    mtt_in_if  byte_ch ();
    mtt_out_if label_ch ();

    markup_tag_tokenizer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (label_ch)
    );

    mtt_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bytes      (byte_ch),
        .i_labels     (label_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Idle length shared by both sides: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Byte pickers for the random markup
    // ------------------------------------------------------------------------

    // Name / unquoted value byte: never one that moves the lexer on.
    function automatic logic [7:0] name_byte();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 80)
            return 8'h61 + 8'($urandom_range(0, 25));
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_GT || c == CH_SPACE || c == CH_QUOTE || c == CH_EQ ||
               c == CH_SLASH);
        return c;
    endfunction

    // Inside quotes: spaces, '>' and newlines are worth hitting often.
    function automatic logic [7:0] quoted_byte();
        logic [7:0] c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return CH_SPACE;
        if (r < 18) return CH_GT;
        if (r < 24) return CH_NL;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE);
        return c;
    endfunction

    // Text byte: anything but '<', with extra newlines.
    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
            return CH_NL;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_LT);
        return c;
    endfunction

    // Junk heavy in delimiters, to break tags in odd places.
    function automatic logic [7:0] delim_byte();
        case ($urandom_range(0, 7))
            0:       return CH_LT;
            1:       return CH_GT;
            2:       return CH_SLASH;
            3:       return CH_EQ;
            4:       return CH_QUOTE;
            5:       return CH_SPACE;
            6:       return CH_NL;
            default: return name_byte();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // One input beat. valid is only lowered when a gap follows, so a valid that
    // stays up between beats never sees two assignments in one step.
    task automatic send_byte(input logic [7:0] c, input logic lst);
        int gap;
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.chr   <= c;
        byte_ch.last  <= lst;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
    endtask

    // Random part: the end-of-text mark falls every so many bytes, sometimes
    // after only a few so that short documents show up too.
    int n_fed;

    task automatic feed(input logic [7:0] c);
        send_byte(c, doc_left == 0);
        n_fed++;
        if (doc_left == 0)
            doc_left = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                                   : $urandom_range(10, 150);
        else
            doc_left--;
    endtask

    // Well-formed tag with random content; now and then the closing '>' is
    // left out so the next fragment lands inside the tag.
    task automatic gen_tag();
        bit is_close;
        is_close = ($urandom_range(0, 3) == 0);
        feed(CH_LT);
        if (is_close)
            feed(CH_SLASH);
        repeat ($urandom_range(1, 8)) feed(name_byte());
        if (is_close) begin
            // junk after a close tag name is skipped up to '>'
            if ($urandom_range(0, 2) == 0) begin
                feed(CH_SPACE);
                repeat ($urandom_range(0, 4)) feed(name_byte());
            end
        end else begin
            repeat ($urandom_range(0, 3)) begin
                feed(($urandom_range(0, 4) == 0) ? CH_QUOTE : CH_SPACE);
                repeat ($urandom_range(1, 6)) feed(name_byte());
                if ($urandom_range(0, 4) != 0) begin
                    feed(CH_EQ);
                    if ($urandom_range(0, 1) == 1) begin
                        feed(CH_QUOTE);
                        repeat ($urandom_range(0, 8)) feed(quoted_byte());
                        feed(CH_QUOTE);
                    end else begin
                        repeat ($urandom_range(1, 6)) feed(name_byte());
                        // unquoted value closed by a stray quote
                        if ($urandom_range(0, 3) == 0)
                            feed(CH_QUOTE);
                    end
                end
            end
        end
        if ($urandom_range(0, 9) != 0)
            feed(CH_GT);
    endtask

    task automatic gen_fragment();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            repeat ($urandom_range(1, 12)) feed(text_byte());
        else if (r < 80)
            gen_tag();
        else if (r < 92)
            repeat ($urandom_range(1, 8)) feed(delim_byte());
        else
            repeat ($urandom_range(1, 6)) feed(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off on request while the
    // sender keeps pushing, so the block fills and stops taking bytes.
    // ------------------------------------------------------------------------
    initial begin : label_sink
        int  n;
        bit  hold_done;
        hold_done = 1'b0;
        label_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                label_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = idle_len();
                if (n > 0) begin
                    label_ch.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                label_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int unsigned n_cycles;
        n_cycles = 0;
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        string doc;
        int    rand_end;
        int    hold_at;

        i_rst_n       <= 1'b0;
        hold_req      <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.chr   <= '0;
        byte_ch.last  <= 1'b0;
        burst    = 1'b0;
        n_fed    = 0;
        doc_left = $urandom_range(10, 150);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed document:
        //   extreme bytes and a dropped newline in text, an empty tag, a close
        //   tag with junk after its name, a tag name ended by a quote, a quoted
        //   value holding a space, '>' and a newline, an unquoted value ended
        //   by a quote, an attribute name ended by '>', then '<' + space and
        //   the final byte landing mid-tag.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        doc = "\n<></b x><a\"k=\" >\n\"m=v\"n>< q";
        for (int i = 0; i < doc.len(); i++)
            send_byte(doc[i], i == doc.len() - 1);

        // Random markup. Part way in, ask for the long output stall and feed
        // back to back for a while so the block backs up.
        rand_end = n_fed + N_RANDOM;
        hold_at  = n_fed + 500;
        while (n_fed < rand_end) begin
            if (!hold_req && n_fed >= hold_at)
                hold_req <= 1'b1;
            burst = (n_fed >= hold_at && n_fed < hold_at + 150) ||
                    ($urandom_range(0, 9) == 0);
            gen_fragment();
        end
        burst = 1'b0;
        byte_ch.valid <= 1'b0;

        // drain: let the last label be queued, then wait it out
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
